@@ rtl/core/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C register-access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_TICK_DIV = 2'd0;

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_QUEUE = 2'd2;

  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [1:0] mode;
    logic       sda_in;
    logic       is_read;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [4:0] byte_count;
    logic [7:0] write_byte;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       scl_drive;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       rejected;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_QUEUE,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       sda;
    logic       is_read;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [4:0] byte_count;
    logic [7:0] write_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_START_C,
    PH_WBIT_LOW,
    PH_WBIT_HIGH,
    PH_ACK_WAIT,
    PH_ACK_HIGH,
    PH_ACK_LOW,
    PH_RD_SETUP,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_RA_HIGH,
    PH_RA_LOW,
    PH_STOP_A,
    PH_STOP_B
  } phase_e;

  typedef enum logic [1:0] {
    ST_ADDR_W,
    ST_REG,
    ST_ADDR_R,
    ST_DATA
  } stage_e;

  typedef struct packed {
    logic scl_lv;
    logic scl_dr;
    logic sda_lv;
    logic sda_dr;
  } pins_t;

endpackage

@@ rtl/core/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: takes words off the input channel and turns the mode code into
// a command for the bus engine queue.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  in_word_t     in_word_i,
  input  fifo_status_t fifo_status_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  cmd_kind_e kind;

  always_comb begin
    case (in_word_i.mode)
      MODE_TICK:  kind = CMD_TICK;
      MODE_START: kind = CMD_START;
      MODE_QUEUE: kind = CMD_QUEUE;
      default:    kind = CMD_NOP;
    endcase
  end

  assign in_stall_o = fifo_status_i.full;
  assign push_o     = in_valid_i && !fifo_status_i.full;

  always_comb begin
    cmd_o             = '0;
    cmd_o.kind        = kind;
    cmd_o.sda         = in_word_i.sda_in;
    cmd_o.is_read     = in_word_i.is_read;
    cmd_o.device_addr = in_word_i.device_addr;
    cmd_o.reg_addr    = in_word_i.reg_addr;
    cmd_o.byte_count  = in_word_i.byte_count;
    cmd_o.write_byte  = in_word_i.write_byte;
  end

endmodule

@@ rtl/core/i2cm_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// i2cm_cmd_fifo
// Short command queue between the input side and the bus engine.
// ----------------------------------------------------------------------------
module i2cm_cmd_fifo import i2cm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cmd_t         cmd_i,
  input  logic         pop_i,
  output cmd_t         cmd_o,
  output fifo_status_t status_o
);

  localparam int unsigned PtrW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CMD_FIFO_DEPTH - 1);

  cmd_t            mem_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(CMD_FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

@@ rtl/core/i2cm_back.sv @@
// ----------------------------------------------------------------------------
// i2cm_back
// Bus engine: runs the start, bit, acknowledge and stop phases one command at
// a time, holds the write byte queue and registers the result word.
// ----------------------------------------------------------------------------
module i2cm_back import i2cm_pkg::*; #(
  parameter int unsigned MAX_BYTES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   tick_div_i,
  input  fifo_status_t fifo_status_i,
  input  cmd_t         cmd_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_word_t    out_word_o
);

  localparam int unsigned CntW = $clog2(MAX_BYTES + 1);
  localparam int unsigned IdxW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BYTES);

  phase_e          phase_q, phase_d;
  stage_e          stage_q, stage_d;
  logic [3:0]      bit_q, bit_d;
  logic [CntW-1:0] done_cnt_q, done_cnt_d;
  logic [7:0]      shift_q, shift_d;
  logic [7:0]      delay_q, delay_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            lat_read_q, lat_read_d;
  logic [6:0]      lat_dev_q, lat_dev_d;
  logic [7:0]      lat_reg_q, lat_reg_d;
  logic [CntW-1:0] lat_cnt_q, lat_cnt_d;
  pins_t           pins_q, pins_d;
  logic [7:0]      queue_q [MAX_BYTES];

  logic            out_valid_q, out_valid_d;
  out_word_t       out_word_q, out_word_d;

  logic            pop;
  logic            step;
  logic            q_we;
  logic [7:0]      div;
  logic [8:0]      dly_inc;
  logic [CntW-1:0] done_inc;
  logic            last_byte;
  logic            fill_full;
  logic [CmpW-1:0] cnt_ext;
  logic [CntW-1:0] cnt_clamp;
  logic [IdxW-1:0] q_idx;
  logic [7:0]      q_byte;
  logic            ld_write, ld_stop, ld_start, ld_read;
  logic [7:0]      wr_byte;
  logic            rdv, rlast, done, rej;

  assign pop       = !fifo_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o     = pop;
  assign div       = (tick_div_i == 8'd0) ? 8'd1 : tick_div_i;
  assign dly_inc   = {1'b0, delay_q} + 9'd1;
  assign done_inc  = done_cnt_q + CntW'(1);
  assign last_byte = (done_inc >= lat_cnt_q);
  assign fill_full = (fill_q >= MaxCnt);
  assign cnt_ext   = CmpW'(cmd_i.byte_count);
  assign cnt_clamp = (cnt_ext > CmpW'(MAX_BYTES)) ? MaxCnt : CntW'(cnt_ext);
  assign q_byte    = queue_q[q_idx];

  always_comb begin : next_state
    phase_d    = phase_q;
    stage_d    = stage_q;
    bit_d      = bit_q;
    done_cnt_d = done_cnt_q;
    shift_d    = shift_q;
    delay_d    = delay_q;
    fill_d     = fill_q;
    lat_read_d = lat_read_q;
    lat_dev_d  = lat_dev_q;
    lat_reg_d  = lat_reg_q;
    lat_cnt_d  = lat_cnt_q;
    pins_d     = pins_q;
    q_we       = 1'b0;
    q_idx      = '0;
    step       = 1'b0;
    ld_write   = 1'b0;
    ld_stop    = 1'b0;
    ld_start   = 1'b0;
    ld_read    = 1'b0;
    wr_byte    = q_byte;

    if (pop) begin
      case (cmd_i.kind)
        CMD_START: begin
          if (phase_q == PH_IDLE) begin
            lat_read_d = cmd_i.is_read;
            lat_dev_d  = cmd_i.device_addr;
            lat_reg_d  = cmd_i.reg_addr;
            lat_cnt_d  = cnt_clamp;
            done_cnt_d = '0;
            bit_d      = '0;
            shift_d    = '0;
            delay_d    = '0;
            stage_d    = ST_ADDR_W;
            if (!cmd_i.is_read) begin
              fill_d = '0;
            end
            ld_start = 1'b1;
          end
        end
        CMD_QUEUE: begin
          if (phase_q == PH_IDLE && !fill_full) begin
            q_we   = 1'b1;
            fill_d = fill_q + CntW'(1);
          end
        end
        CMD_TICK: begin
          if (phase_q == PH_ACK_WAIT) begin
            if (!cmd_i.sda) begin
              pins_d.scl_lv = 1'b1;
              pins_d.scl_dr = 1'b1;
              delay_d       = '0;
              phase_d       = PH_ACK_HIGH;
            end
          end else if (phase_q != PH_IDLE) begin
            if (dly_inc >= {1'b0, div}) begin
              delay_d = '0;
              step    = 1'b1;
            end else begin
              delay_d = dly_inc[7:0];
            end
          end
        end
        default: ;
      endcase
    end

    if (step) begin
      case (phase_q)
        PH_START_A: begin
          pins_d.sda_lv = 1'b0;
          pins_d.sda_dr = 1'b1;
          phase_d       = PH_START_B;
        end
        PH_START_B: begin
          pins_d.scl_lv = 1'b0;
          pins_d.scl_dr = 1'b1;
          phase_d       = PH_START_C;
        end
        PH_START_C: begin
          ld_write = 1'b1;
          if (stage_q == ST_ADDR_R) begin
            wr_byte = {lat_dev_q, 1'b0} | ADDR_RD_BIT;
          end else begin
            wr_byte = {lat_dev_q, 1'b0} & ADDR_WR_MASK;
          end
        end
        PH_WBIT_LOW: begin
          pins_d.scl_lv = 1'b1;
          pins_d.scl_dr = 1'b1;
          phase_d       = PH_WBIT_HIGH;
        end
        PH_WBIT_HIGH: begin
          pins_d.scl_lv = 1'b0;
          pins_d.scl_dr = 1'b1;
          bit_d         = bit_q + 4'd1;
          shift_d       = {shift_q[6:0], 1'b0};
          if (bit_d < BITS_PER_BYTE) begin
            pins_d.sda_lv = shift_d[7];
            pins_d.sda_dr = 1'b1;
            phase_d       = PH_WBIT_LOW;
          end else begin
            pins_d.sda_dr = 1'b0;
            phase_d       = PH_ACK_WAIT;
          end
        end
        PH_ACK_HIGH: begin
          pins_d.scl_lv = 1'b0;
          pins_d.scl_dr = 1'b1;
          phase_d       = PH_ACK_LOW;
        end
        PH_ACK_LOW: begin
          pins_d.sda_lv = 1'b0;
          pins_d.sda_dr = 1'b1;
          case (stage_q)
            ST_ADDR_W: begin
              stage_d  = ST_REG;
              ld_write = 1'b1;
              wr_byte  = lat_reg_q;
            end
            ST_REG: begin
              if (lat_read_q) begin
                stage_d  = ST_ADDR_R;
                ld_start = 1'b1;
              end else begin
                stage_d = ST_DATA;
                q_idx   = '0;
                if (lat_cnt_q != '0) begin
                  ld_write = 1'b1;
                end else begin
                  ld_stop = 1'b1;
                end
              end
            end
            ST_ADDR_R: begin
              stage_d = ST_DATA;
              if (lat_cnt_q != '0) begin
                ld_read = 1'b1;
              end else begin
                ld_stop = 1'b1;
              end
            end
            default: begin
              done_cnt_d = done_inc;
              q_idx      = done_inc[IdxW-1:0];
              if (done_inc < lat_cnt_q) begin
                ld_write = 1'b1;
              end else begin
                ld_stop = 1'b1;
              end
            end
          endcase
        end
        PH_RD_SETUP: begin
          pins_d.scl_lv = 1'b1;
          pins_d.scl_dr = 1'b1;
          phase_d       = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          shift_d       = {shift_q[6:0], cmd_i.sda};
          bit_d         = bit_q + 4'd1;
          pins_d.scl_lv = 1'b0;
          pins_d.scl_dr = 1'b1;
          phase_d       = PH_RD_LOW;
        end
        PH_RD_LOW: begin
          pins_d.scl_lv = 1'b1;
          pins_d.scl_dr = 1'b1;
          if (bit_q < BITS_PER_BYTE) begin
            phase_d = PH_RD_HIGH;
          end else begin
            pins_d.sda_lv = last_byte;
            pins_d.sda_dr = 1'b1;
            phase_d       = PH_RA_HIGH;
          end
        end
        PH_RA_HIGH: begin
          pins_d.scl_lv = 1'b0;
          pins_d.scl_dr = 1'b1;
          phase_d       = PH_RA_LOW;
        end
        PH_RA_LOW: begin
          done_cnt_d = done_inc;
          if (done_inc < lat_cnt_q) begin
            ld_read = 1'b1;
          end else begin
            ld_stop = 1'b1;
          end
        end
        PH_STOP_A: begin
          pins_d.sda_lv = 1'b1;
          pins_d.sda_dr = 1'b1;
          phase_d       = PH_STOP_B;
        end
        PH_STOP_B: begin
          pins_d  = '{scl_lv: 1'b1, scl_dr: 1'b0, sda_lv: 1'b1, sda_dr: 1'b0};
          phase_d = PH_IDLE;
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    if (ld_write) begin
      shift_d       = wr_byte;
      bit_d         = '0;
      pins_d.scl_lv = 1'b0;
      pins_d.scl_dr = 1'b1;
      pins_d.sda_lv = wr_byte[7];
      pins_d.sda_dr = 1'b1;
      phase_d       = PH_WBIT_LOW;
    end
    if (ld_stop) begin
      pins_d  = '{scl_lv: 1'b1, scl_dr: 1'b1, sda_lv: 1'b0, sda_dr: 1'b1};
      phase_d = PH_STOP_A;
    end
    if (ld_start) begin
      pins_d  = '{scl_lv: 1'b1, scl_dr: 1'b1, sda_lv: 1'b1, sda_dr: 1'b1};
      phase_d = PH_START_A;
    end
    if (ld_read) begin
      shift_d       = '0;
      bit_d         = '0;
      pins_d.sda_dr = 1'b0;
      phase_d       = PH_RD_SETUP;
    end
  end

  always_comb begin : result
    rej = pop && (((cmd_i.kind == CMD_START) && (phase_q != PH_IDLE)) ||
                  ((cmd_i.kind == CMD_QUEUE) && ((phase_q != PH_IDLE) || fill_full)));
    rdv   = step && (phase_q == PH_RD_HIGH) && (bit_d >= BITS_PER_BYTE);
    rlast = rdv && last_byte;
    done  = step && (phase_q == PH_STOP_B);

    out_word_d.scl_level  = pins_d.scl_lv;
    out_word_d.scl_drive  = pins_d.scl_dr;
    out_word_d.sda_level  = pins_d.sda_lv;
    out_word_d.sda_drive  = pins_d.sda_dr;
    out_word_d.read_byte  = rdv ? shift_d : 8'd0;
    out_word_d.read_valid = rdv;
    out_word_d.read_last  = rlast;
    out_word_d.busy_res   = (phase_d != PH_IDLE);
    out_word_d.done_res   = done;
    out_word_d.rejected   = rej;

    out_valid_d = pop || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      stage_q     <= ST_ADDR_W;
      bit_q       <= '0;
      done_cnt_q  <= '0;
      shift_q     <= '0;
      delay_q     <= '0;
      fill_q      <= '0;
      lat_read_q  <= 1'b0;
      lat_dev_q   <= '0;
      lat_reg_q   <= '0;
      lat_cnt_q   <= '0;
      pins_q      <= '{scl_lv: 1'b1, scl_dr: 1'b0, sda_lv: 1'b1, sda_dr: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      stage_q     <= stage_d;
      bit_q       <= bit_d;
      done_cnt_q  <= done_cnt_d;
      shift_q     <= shift_d;
      delay_q     <= delay_d;
      fill_q      <= fill_d;
      lat_read_q  <= lat_read_d;
      lat_dev_q   <= lat_dev_d;
      lat_reg_q   <= lat_reg_d;
      lat_cnt_q   <= lat_cnt_d;
      pins_q      <= pins_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_word_q <= out_word_d;
    end
    if (q_we) begin
      queue_q[fill_q[IdxW-1:0]] <= cmd_i.write_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ rtl/core/i2c_master_register_access.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Bit-level I2C master running register read and write transactions, one
// tick word per delay-unit count, with an APB-style divider register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  input   | in        | in_valid_i / in_stall_o    | in_word_i  (in_word_t)
//  output  | out       | out_valid_o / out_stall_i  | out_word_o (out_word_t)
//  config  | in/out    | psel, penable, pwrite      | paddr, pwdata, prdata
//
//  One word in, one word out; the engine retires one per cycle if not stalled.
//  Each word passes the command queue, then the registered result stage.
//  Reset clears the engine to idle with both lines released high.
//  A stalled output holds its word; input stalls only once the two-entry
//  command queue is full.
// ----------------------------------------------------------------------------
module i2c_master_register_access import i2cm_pkg::*; #(
  parameter int unsigned MAX_BYTES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic         push;
  logic         pop;
  cmd_t         cmd_in;
  cmd_t         cmd_out;
  fifo_status_t fifo_status;
  logic [7:0]   tick_div_q, tick_div_d;
  logic         reg_wr;

  assign pready     = 1'b1;
  assign reg_wr     = psel && penable && pwrite && (paddr == REG_TICK_DIV);
  assign tick_div_d = reg_wr ? pwdata[7:0] : tick_div_q;
  assign prdata     = (paddr == REG_TICK_DIV) ? APB_DATA_W'(tick_div_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q <= 8'd1;
    end else begin
      tick_div_q <= tick_div_d;
    end
  end

  i2cm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_word_i     (in_word_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  i2cm_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_out),
    .status_o (fifo_status)
  );

  i2cm_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_div_i    (tick_div_q),
    .fifo_status_i (fifo_status),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

endmodule

@@ rtl/core/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C register-access master, bound to the top.
// ----------------------------------------------------------------------------
module i2cm_checker import i2cm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_word_t              in_word_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_word_t             out_word_o,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.read_valid |-> out_word_o.busy_res)
    else $error("read byte reported outside a transaction");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.done_res |->
      !out_word_o.busy_res && !out_word_o.scl_drive && !out_word_o.sda_drive)
    else $error("stop finished without releasing the bus");

  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.rejected |->
      !out_word_o.read_valid && !out_word_o.done_res)
    else $error("rejected word carries bus events");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.read_last |-> out_word_o.read_valid)
    else $error("last flag without a read byte");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick, start and queue words into the I2C register-access master and
// checks every result word against a fixed value or an in-bench bus model:
// a directed table first, then random write and read transactions with noise,
// over several divider settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import i2cm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUEUE_DEPTH = 16;
  localparam int UNTIL_IDLE = 0;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 210;
  localparam int unsigned DIV_PLAN [10] = '{0, 2, 1, 255, 3, 7, 1, 4, 2, 1};

  localparam out_word_t OUT_IDLE =
    '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam out_word_t OUT_FULL =
    '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam out_word_t OUT_START =
    '{1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam out_word_t OUT_START_REJ =
    '{1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct {
    in_word_t  w;
    int        reps;
    bit        fixed;
    out_word_t res;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  i2c_master_register_access u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bus sequencer model state
  logic [7:0] div_q = 8'd1;
  phase_e     ph = PH_IDLE;
  stage_e     stg = ST_ADDR_W;
  logic [3:0] bit_cnt = '0;
  logic [4:0] done_cnt = '0;
  logic [7:0] shifter = '0;
  logic [7:0] tick_cnt = '0;
  logic [7:0] wq [QUEUE_DEPTH];
  int         fill = 0;
  int         hwm = 0;
  logic       txn_rd = 1'b0;
  logic [6:0] txn_dev = '0;
  logic [7:0] txn_reg = '0;
  logic [4:0] txn_cnt = '0;
  pins_t      pins = '{1'b1, 1'b0, 1'b1, 1'b0};

  out_word_t  pending_res [$];
  int         n_errors = 0;
  int         n_reported = 0;
  int         n_sent = 0;
  int         quiet = 0;
  bit         calm = 1'b0;
  bit         valid_up = 1'b0;

  plan_row_t plan [24] = '{
    '{'{MODE_TICK, 1'b0, 1'b0, 7'h00, 8'h00, 5'd0, 8'h00}, 1, 1'b1, OUT_IDLE},
    '{'{MODE_UNUSED, 1'b1, 1'b1, 7'h7F, 8'hFF, 5'd31, 8'hFF}, 1, 1'b1, OUT_IDLE},
    '{'{MODE_TICK, 1'b1, 1'b1, 7'h7F, 8'hFF, 5'd31, 8'hFF}, 1, 1'b1, OUT_IDLE},
    '{'{MODE_QUEUE, 1'b0, 1'b0, 7'h00, 8'h00, 5'd0, 8'hFF}, 1, 1'b1, OUT_IDLE},
    '{'{MODE_QUEUE, 1'b1, 1'b1, 7'h7F, 8'hFF, 5'd31, 8'h00}, 1, 1'b1, OUT_IDLE},
    '{'{MODE_QUEUE, 1'b0, 1'b0, 7'h00, 8'h00, 5'd0, 8'h5A}, 13, 1'b1, OUT_IDLE},
    '{'{MODE_QUEUE, 1'b0, 1'b0, 7'h00, 8'h00, 5'd0, 8'h96}, 1, 1'b1, OUT_IDLE},
    '{'{MODE_QUEUE, 1'b0, 1'b0, 7'h00, 8'h00, 5'd0, 8'hC3}, 1, 1'b1, OUT_FULL},
    '{'{MODE_START, 1'b0, 1'b0, 7'h7F, 8'hFF, 5'd31, 8'h00}, 1, 1'b1, OUT_START},
    '{'{MODE_START, 1'b0, 1'b1, 7'h00, 8'h00, 5'd1, 8'h00}, 1, 1'b1, OUT_START_REJ},
    '{'{MODE_QUEUE, 1'b0, 1'b0, 7'h00, 8'h00, 5'd0, 8'h11}, 1, 1'b1, OUT_START_REJ},
    '{'0, UNTIL_IDLE, 1'b0, '0},
    '{'{MODE_START, 1'b0, 1'b1, 7'h00, 8'h00, 5'd1, 8'h00}, 1, 1'b1, OUT_START},
    '{'0, UNTIL_IDLE, 1'b0, '0},
    '{'{MODE_START, 1'b0, 1'b1, 7'h55, 8'hAA, 5'd3, 8'h00}, 1, 1'b1, OUT_START},
    '{'0, UNTIL_IDLE, 1'b0, '0},
    '{'{MODE_START, 1'b0, 1'b0, 7'h2A, 8'h01, 5'd0, 8'h00}, 1, 1'b1, OUT_START},
    '{'0, UNTIL_IDLE, 1'b0, '0},
    '{'{MODE_START, 1'b0, 1'b1, 7'h7F, 8'h80, 5'd0, 8'h00}, 1, 1'b1, OUT_START},
    '{'0, UNTIL_IDLE, 1'b0, '0},
    '{'{MODE_START, 1'b0, 1'b0, 7'h01, 8'h7E, 5'd2, 8'h00}, 1, 1'b1, OUT_START},
    '{'0, UNTIL_IDLE, 1'b0, '0},
    '{'{MODE_START, 1'b0, 1'b1, 7'h33, 8'h0F, 5'd16, 8'h00}, 1, 1'b1, OUT_START},
    '{'0, UNTIL_IDLE, 1'b0, '0}
  };

  function automatic int unit_ticks();
    return (div_q == 8'd0) ? 1 : int'(div_q);
  endfunction

  function automatic int eff_cnt();
    return (txn_cnt > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(txn_cnt);
  endfunction

  function automatic void drive_scl(logic lv);
    pins.scl_lv = lv;
    pins.scl_dr = 1'b1;
  endfunction

  function automatic void drive_sda(logic lv);
    pins.sda_lv = lv;
    pins.sda_dr = 1'b1;
  endfunction

  function automatic void load_byte(logic [7:0] b);
    shifter = b;
    bit_cnt = '0;
    drive_scl(1'b0);
    drive_sda(b[7]);
    ph = PH_WBIT_LOW;
  endfunction

  function automatic void load_read();
    shifter = '0;
    bit_cnt = '0;
    pins.sda_dr = 1'b0;
    ph = PH_RD_SETUP;
  endfunction

  function automatic void open_bus();
    drive_sda(1'b1);
    drive_scl(1'b1);
    ph = PH_START_A;
  endfunction

  function automatic void close_bus();
    drive_sda(1'b0);
    drive_scl(1'b1);
    ph = PH_STOP_A;
  endfunction

  // advances the model by one accepted word and returns the word it answers
  function automatic out_word_t bus_predict(in_word_t w);
    out_word_t r;
    logic rdv, rlast, fin, rej;
    rdv = 1'b0;
    rlast = 1'b0;
    fin = 1'b0;
    rej = 1'b0;
    case (w.mode)
      MODE_START: begin
        if (ph != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          txn_rd = w.is_read;
          txn_dev = w.device_addr;
          txn_reg = w.reg_addr;
          txn_cnt = w.byte_count;
          done_cnt = '0;
          bit_cnt = '0;
          shifter = '0;
          tick_cnt = '0;
          stg = ST_ADDR_W;
          if (!w.is_read) fill = 0;
          open_bus();
        end
      end
      MODE_QUEUE: begin
        if (ph != PH_IDLE || fill >= QUEUE_DEPTH) begin
          rej = 1'b1;
        end else begin
          wq[fill] = w.write_byte;
          fill++;
          if (fill > hwm) hwm = fill;
        end
      end
      MODE_TICK: begin
        if (ph == PH_ACK_WAIT) begin
          if (!w.sda_in) begin
            drive_scl(1'b1);
            tick_cnt = '0;
            ph = PH_ACK_HIGH;
          end
        end else if (ph != PH_IDLE) begin
          tick_cnt++;
          if (tick_cnt >= unit_ticks()) begin
            tick_cnt = '0;
            case (ph)
              PH_START_A: begin
                drive_sda(1'b0);
                ph = PH_START_B;
              end
              PH_START_B: begin
                drive_scl(1'b0);
                ph = PH_START_C;
              end
              PH_START_C: begin
                if (stg == ST_ADDR_R) load_byte({txn_dev, 1'b0} | ADDR_RD_BIT);
                else load_byte({txn_dev, 1'b0} & ADDR_WR_MASK);
              end
              PH_WBIT_LOW: begin
                drive_scl(1'b1);
                ph = PH_WBIT_HIGH;
              end
              PH_WBIT_HIGH: begin
                drive_scl(1'b0);
                bit_cnt++;
                shifter = shifter << 1;
                if (bit_cnt < 8) begin
                  drive_sda(shifter[7]);
                  ph = PH_WBIT_LOW;
                end else begin
                  pins.sda_dr = 1'b0;
                  ph = PH_ACK_WAIT;
                end
              end
              PH_ACK_HIGH: begin
                drive_scl(1'b0);
                ph = PH_ACK_LOW;
              end
              PH_ACK_LOW: begin
                drive_sda(1'b0);
                case (stg)
                  ST_ADDR_W: begin
                    stg = ST_REG;
                    load_byte(txn_reg);
                  end
                  ST_REG: begin
                    if (txn_rd) begin
                      stg = ST_ADDR_R;
                      open_bus();
                    end else begin
                      stg = ST_DATA;
                      if (eff_cnt() > 0) load_byte(wq[0]);
                      else close_bus();
                    end
                  end
                  ST_ADDR_R: begin
                    stg = ST_DATA;
                    if (eff_cnt() > 0) load_read();
                    else close_bus();
                  end
                  default: begin
                    done_cnt++;
                    if (done_cnt < eff_cnt()) load_byte(wq[done_cnt]);
                    else close_bus();
                  end
                endcase
              end
              PH_RD_SETUP: begin
                drive_scl(1'b1);
                ph = PH_RD_HIGH;
              end
              PH_RD_HIGH: begin
                shifter = {shifter[6:0], w.sda_in};
                bit_cnt++;
                drive_scl(1'b0);
                ph = PH_RD_LOW;
                if (bit_cnt >= 8) begin
                  rdv = 1'b1;
                  rlast = (done_cnt + 1 >= eff_cnt());
                end
              end
              PH_RD_LOW: begin
                if (bit_cnt < 8) begin
                  drive_scl(1'b1);
                  ph = PH_RD_HIGH;
                end else begin
                  drive_sda(done_cnt + 1 >= eff_cnt());
                  drive_scl(1'b1);
                  ph = PH_RA_HIGH;
                end
              end
              PH_RA_HIGH: begin
                drive_scl(1'b0);
                ph = PH_RA_LOW;
              end
              PH_RA_LOW: begin
                done_cnt++;
                if (done_cnt < eff_cnt()) load_read();
                else close_bus();
              end
              PH_STOP_A: begin
                drive_sda(1'b1);
                ph = PH_STOP_B;
              end
              PH_STOP_B: begin
                pins = '{1'b1, 1'b0, 1'b1, 1'b0};
                ph = PH_IDLE;
                fin = 1'b1;
              end
              default: ph = PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase
    r.scl_level = pins.scl_lv;
    r.scl_drive = pins.scl_dr;
    r.sda_level = pins.sda_lv;
    r.sda_drive = pins.sda_dr;
    r.read_byte = rdv ? shifter : 8'h00;
    r.read_valid = rdv;
    r.read_last = rdv & rlast;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = fin;
    r.rejected = rej;
    return r;
  endfunction

  function automatic int pause_len();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = in_word_t'($urandom);
    w.mode = MODE_TICK;
    return w;
  endfunction

  // start word whose byte count never reaches unwritten queue entries
  function automatic in_word_t start_word(bit rd);
    in_word_t w;
    int cap;
    w = in_word_t'($urandom);
    w.mode = MODE_START;
    if (unit_ticks() >= 8) rd = 1'b0;
    w.is_read = rd;
    if (unit_ticks() <= 1) cap = ($urandom_range(0, 5) == 0) ? 16 : 4;
    else if (unit_ticks() <= 4) cap = 2;
    else if (unit_ticks() < 8) cap = 1;
    else cap = 0;
    if (!rd && cap > hwm) cap = hwm;
    w.byte_count = $urandom_range(0, cap);
    if (w.byte_count == 5'd16 && $urandom_range(0, 1) == 1)
      w.byte_count = $urandom_range(17, 31);
    return w;
  endfunction

  function automatic in_word_t stray_word();
    in_word_t w;
    w = in_word_t'($urandom);
    if (w.mode == MODE_START && ph == PH_IDLE) w = start_word(w.is_read);
    return w;
  endfunction

  function automatic void note_error(string msg);
    n_errors++;
    if (n_reported < 10) begin
      n_reported++;
      $display("%0t ERROR %s", $realtime, msg);
    end
  endfunction

  function automatic void match_field(string name, logic [7:0] exp, logic [7:0] got);
    if (got !== exp)
      note_error($sformatf("%s: expected %0h, got %0h", name, exp, got));
  endfunction

  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t fixed_res);
    int gap;
    out_word_t p;
    gap = pause_len();
    if (gap > 0) begin
      if (valid_up) in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    valid_up = 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    p = bus_predict(w);
    pending_res.push_back(fixed ? fixed_res : p);
    n_sent++;
  endtask

  task automatic hold_off();
    if (valid_up) in_valid_i <= 1'b0;
    valid_up = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [7:0] data,
                          output logic [APB_DATA_W-1:0] rd);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= REG_TICK_DIV;
    pwdata <= APB_DATA_W'(data);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_divider(input logic [7:0] value);
    logic [APB_DATA_W-1:0] rd;
    hold_off();
    wait_drained();
    apb_xfer(1'b1, value, rd);
    div_q = value;
    apb_xfer(1'b0, 8'h00, rd);
    match_field("tick_divider", value, rd[7:0]);
  endtask

  always @(posedge clk_i) begin
    out_word_t e;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_res.size() == 0) begin
        note_error($sformatf("result word %0h with none pending", out_word_o));
      end else begin
        e = pending_res.pop_front();
        match_field("scl_level", e.scl_level, out_word_o.scl_level);
        match_field("scl_drive", e.scl_drive, out_word_o.scl_drive);
        match_field("sda_level", e.sda_level, out_word_o.sda_level);
        match_field("sda_drive", e.sda_drive, out_word_o.sda_drive);
        match_field("read_byte", e.read_byte, out_word_o.read_byte);
        match_field("read_valid", e.read_valid, out_word_o.read_valid);
        match_field("read_last", e.read_last, out_word_o.read_last);
        match_field("busy_res", e.busy_res, out_word_o.busy_res);
        match_field("done_res", e.done_res, out_word_o.done_res);
        match_field("rejected", e.rejected, out_word_o.rejected);
      end
    end
  end

  initial begin
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      n = pause_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1 || out_stall_i !== 1'b0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int k;
    int phase_end;
    in_word_t qw;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].reps == UNTIL_IDLE) begin
        while (ph != PH_IDLE) send_word(tick_word(), 1'b0, '0);
      end else begin
        repeat (plan[i].reps) send_word(plan[i].w, plan[i].fixed, plan[i].res);
      end
    end

    foreach (DIV_PLAN[i]) begin
      set_divider(DIV_PLAN[i][7:0]);
      // one short write at the largest divider, back to back
      if (unit_ticks() >= 8) calm = 1'b1;
      phase_end = n_sent + ((unit_ticks() >= 8) ? 1 : PHASE_WORDS);
      while (n_sent < phase_end || ph != PH_IDLE) begin
        if (unit_ticks() < 8 && $urandom_range(0, 99) == 0) calm = !calm;
        if (ph != PH_IDLE) begin
          if ($urandom_range(0, 19) == 0) send_word(stray_word(), 1'b0, '0);
          else send_word(tick_word(), 1'b0, '0);
        end else if (unit_ticks() >= 8) begin
          send_word(start_word(1'b0), 1'b0, '0);
        end else begin
          r = $urandom_range(0, 39);
          if (r == 0) begin
            hold_off();
            wait_drained();
          end else if (r < 16) begin
            k = ($urandom_range(0, 3) == 0) ? QUEUE_DEPTH + 1 : $urandom_range(0, 4);
            repeat (k) begin
              qw = in_word_t'($urandom);
              qw.mode = MODE_QUEUE;
              send_word(qw, 1'b0, '0);
            end
            send_word(start_word(1'b0), 1'b0, '0);
          end else if (r < 28) begin
            send_word(start_word(1'b1), 1'b0, '0);
          end else begin
            repeat ($urandom_range(1, 4)) send_word(stray_word(), 1'b0, '0);
          end
        end
      end
      calm = 1'b0;
    end

    hold_off();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && pending_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
